// ===== rtl/core/mf9_pkg.sv =====
// ----------------------------------------------------------------------------
// mf9_pkg: shared types and constants of the 9x9 median filter
// Geometry limits, stream item layouts and the configuration register map.
// ----------------------------------------------------------------------------
package mf9_pkg;

    localparam int DATA_W      = 8;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_COMP    = 4;
    localparam int RADIUS      = 4;
    localparam int WIN_SIDE    = 2 * RADIUS + 1;
    localparam int WIN_COUNT   = WIN_SIDE * WIN_SIDE;
    localparam int MEDIAN_RANK = WIN_COUNT / 2 + 1;
    localparam int RANK_W      = $clog2(WIN_COUNT + 1);
    localparam int LINE_BYTES  = MAX_WIDTH * MAX_COMP;
    localparam int COL_W       = $clog2(LINE_BYTES);
    localparam int RB_W        = $clog2(LINE_BYTES + 1);
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int COMP_W      = 3;
    localparam int ROW_W       = HEIGHT_W;
    localparam int LEAD_W      = $clog2(RADIUS * LINE_BYTES + RADIUS * MAX_COMP + 1);
    localparam int LB_ROWS     = 2 * RADIUS;
    localparam int LB_W        = LB_ROWS * DATA_W;
    localparam int WIN_TAPS    = 2 * RADIUS * MAX_COMP + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;

    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int RST_COMP_COUNT   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_COMP_COUNT   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] pixel_byte;
        logic              flush;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] median_byte;
        logic              last_of_frame;
    } t_out_item;

    // effective frame geometry, derived from the configuration registers
    typedef struct packed {
        logic [RB_W-1:0]   row_bytes;
        logic [ROW_W-1:0]  rows;
        logic [COMP_W-1:0] comp;
        logic [LEAD_W-1:0] lag;
    } t_geom;

    // one raster step handed from the front to the back
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [COL_W-1:0]  col;
        logic              emit;
        logic              last;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
    } t_step;

    typedef logic [WIN_COUNT-1:0][DATA_W-1:0] t_win_vals;

endpackage

// ===== rtl/core/mf9_ram.sv =====
// ----------------------------------------------------------------------------
// mf9_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module mf9_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mf9_queue.sv =====
// ----------------------------------------------------------------------------
// mf9_queue: step queue between front and back
// Small FIFO of raster steps so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mf9_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mf9_pkg::t_step  i_item,
    input  logic            i_pop,
    output mf9_pkg::t_step  o_head,
    output logic            o_nempty,
    output logic            o_full
);

    localparam int PTR_W = $clog2(mf9_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mf9_pkg::QUEUE_DEPTH + 1);

    mf9_pkg::t_step   r_mem [mf9_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_head   = r_mem[r_rptr];
    assign o_nempty = (r_count != '0);
    assign o_full   = (r_count == CNT_W'(mf9_pkg::QUEUE_DEPTH));

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("step popped from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(mf9_pkg::QUEUE_DEPTH)))
        else $error("step pushed into full queue");

endmodule

// ===== rtl/core/mf9_front.sv =====
// ----------------------------------------------------------------------------
// mf9_front: input sequencer
// Accepts transactions, drops early flushes, tracks input and output raster
// positions and hands one step per remaining transaction to the queue.
// ----------------------------------------------------------------------------
module mf9_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mf9_pkg::t_geom    i_geom,
    input  logic              i_restart,
    input  logic              i_valid,
    output logic              o_ready,
    input  mf9_pkg::t_in_item i_data,
    input  logic              i_full,
    output logic              o_push,
    output mf9_pkg::t_step    o_item
);

    localparam int RB_W = mf9_pkg::RB_W;

    logic [mf9_pkg::COL_W-1:0]  r_in_col, n_in_col;
    logic [mf9_pkg::ROW_W-1:0]  r_in_row, n_in_row;
    logic [mf9_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic [mf9_pkg::ROW_W-1:0]  r_out_row, n_out_row;
    logic [mf9_pkg::COL_W-1:0]  r_step_col, n_step_col;
    logic [mf9_pkg::LEAD_W-1:0] r_lead, n_lead;

    logic            accept, in_frame, ignore, emit, last;
    logic [RB_W-1:0] in_col_nx, out_col_nx, step_col_nx;
    logic [mf9_pkg::ROW_W-1:0] out_row_nx;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign in_frame = (r_in_row < i_geom.rows);
    assign ignore   = in_frame && i_data.flush;
    assign emit     = (r_lead >= i_geom.lag);

    assign in_col_nx   = RB_W'(r_in_col) + RB_W'(1);
    assign out_col_nx  = RB_W'(r_out_col) + RB_W'(1);
    assign step_col_nx = RB_W'(r_step_col) + RB_W'(1);
    assign out_row_nx  = (out_col_nx >= i_geom.row_bytes) ? r_out_row + 1'b1 : r_out_row;
    assign last        = emit && (out_row_nx >= i_geom.rows);

    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_step_col = r_step_col;
        n_lead     = r_lead;
        if (i_restart) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_step_col = '0;
            n_lead     = '0;
        end else if (accept && !ignore) begin
            if (in_frame) begin
                if (in_col_nx >= i_geom.row_bytes) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = in_col_nx[mf9_pkg::COL_W-1:0];
                end
            end
            // line buffer column runs on through the drain
            if (step_col_nx >= i_geom.row_bytes) begin
                n_step_col = '0;
            end else begin
                n_step_col = step_col_nx[mf9_pkg::COL_W-1:0];
            end
            if (!emit) begin
                n_lead = r_lead + 1'b1;
            end else begin
                n_out_row = out_row_nx;
                if (out_col_nx >= i_geom.row_bytes) begin
                    n_out_col = '0;
                end else begin
                    n_out_col = out_col_nx[mf9_pkg::COL_W-1:0];
                end
            end
            if (last) begin
                n_in_col   = '0;
                n_in_row   = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_step_col = '0;
                n_lead     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_step_col <= '0;
            r_lead     <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_step_col <= n_step_col;
            r_lead     <= n_lead;
        end
    end

    assign o_push         = accept && !ignore;
    assign o_item.data    = i_data.pixel_byte;
    assign o_item.col     = r_step_col;
    assign o_item.emit    = emit;
    assign o_item.last    = last;
    assign o_item.out_row = r_out_row;
    assign o_item.out_col = r_out_col;

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.last && !i_restart)
        |=> (r_in_row == '0 && r_lead == '0 && r_out_row == '0 && r_step_col == '0))
        else $error("frame counters not cleared after last output");

endmodule

// ===== rtl/core/mf9_median.sv =====
// ----------------------------------------------------------------------------
// mf9_median: pipelined rank selection over the 81-value window
// One bit per stage, MSB first: count live zeros, pick the bit, trim the set.
// ----------------------------------------------------------------------------
module mf9_median (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic                       i_last,
    input  mf9_pkg::t_win_vals         i_vals,
    output logic                       o_valid,
    output logic                       o_last,
    output logic [mf9_pkg::DATA_W-1:0] o_median
);

    localparam int STAGES = mf9_pkg::DATA_W;
    localparam int N      = mf9_pkg::WIN_COUNT;
    localparam int K_W    = mf9_pkg::RANK_W;

    logic [mf9_pkg::DATA_W-1:0] r_val   [STAGES][N];
    logic [N-1:0]               r_alive [STAGES];
    logic [K_W-1:0]             r_k     [STAGES];
    logic [mf9_pkg::DATA_W-1:0] r_res   [STAGES+1];
    logic                       r_vld   [STAGES+1];
    logic                       r_lst   [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            for (int j = 0; j < N; j++) begin
                r_val[0][j] <= i_vals[j];
            end
            r_alive[0] <= '1;
            r_k[0]     <= K_W'(mf9_pkg::MEDIAN_RANK);
            r_res[0]   <= '0;
            r_lst[0]   <= i_last;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int BIT = mf9_pkg::DATA_W - 1 - g;

        logic [K_W-1:0]             cnt0;
        logic                       one;
        logic [N-1:0]               alive_nx;
        logic [mf9_pkg::DATA_W-1:0] res_nx;

        always_comb begin
            cnt0 = '0;
            for (int j = 0; j < N; j++) begin
                cnt0 = cnt0 + K_W'(r_alive[g][j] & ~r_val[g][j][BIT]);
            end
            one = (r_k[g] > cnt0);
            for (int j = 0; j < N; j++) begin
                alive_nx[j] = r_alive[g][j] & (r_val[g][j][BIT] == one);
            end
            res_nx      = r_res[g];
            res_nx[BIT] = one;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_res[g+1] <= res_nx;
                r_lst[g+1] <= r_lst[g];
            end
        end

        if (g < STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int j = 0; j < N; j++) begin
                        r_val[g+1][j] <= r_val[g][j];
                    end
                    r_alive[g+1] <= alive_nx;
                    r_k[g+1]     <= one ? r_k[g] - cnt0 : r_k[g];
                end
            end
        end
    end

    assign o_valid  = r_vld[STAGES];
    assign o_last   = r_lst[STAGES];
    assign o_median = r_res[STAGES];

endmodule

// ===== rtl/core/mf9_back.sv =====
// ----------------------------------------------------------------------------
// mf9_back: line buffer, window and median datapath
// Packed 8-row line buffer in one RAM, 9-row window shift lines, edge
// masking, rank selection and the output register.
// ----------------------------------------------------------------------------
module mf9_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mf9_pkg::t_geom     i_geom,
    input  logic               i_q_nempty,
    input  mf9_pkg::t_step     i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output mf9_pkg::t_out_item o_data
);

    localparam int DW     = mf9_pkg::DATA_W;
    localparam int SIDE   = mf9_pkg::WIN_SIDE;
    localparam int RAD    = mf9_pkg::RADIUS;
    localparam int RPOS_W = mf9_pkg::ROW_W + 2;
    localparam int CPOS_W = mf9_pkg::RB_W + 2;

    logic en, ram_we;
    logic [mf9_pkg::LB_W-1:0] ram_rdata, lb_word, lb_wdata;

    logic                     r_s1_valid;
    mf9_pkg::t_step           r_s1;
    logic                     r_s1_fwd;
    logic [mf9_pkg::LB_W-1:0] r_s1_fwd_word;

    logic [DW-1:0] r_win [SIDE][mf9_pkg::WIN_TAPS];
    logic [DW-1:0] column [SIDE];

    logic                      r_s2_valid;
    logic                      r_s2_emit;
    logic                      r_s2_last;
    logic [mf9_pkg::ROW_W-1:0] r_s2_out_row;
    logic [mf9_pkg::COL_W-1:0] r_s2_out_col;

    mf9_pkg::t_win_vals vals;
    logic               med_valid, med_last;
    logic [DW-1:0]      med_byte;

    logic               r_out_valid;
    mf9_pkg::t_out_item r_out;

    // whole datapath advances together, held only by a waiting result
    assign en      = !r_out_valid || i_ready;
    assign o_q_pop = en && i_q_nempty;
    assign ram_we  = en && r_s1_valid;

    assign lb_word  = r_s1_fwd ? r_s1_fwd_word : ram_rdata;
    assign lb_wdata = {lb_word[mf9_pkg::LB_W-DW-1:0], r_s1.data};

    mf9_ram #(
        .WIDTH (mf9_pkg::LB_W),
        .DEPTH (mf9_pkg::LINE_BYTES)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.col),
        .i_wdata (lb_wdata),
        .i_re    (o_q_pop),
        .i_raddr (i_q_item.col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        column[0] = r_s1.data;
        for (int d = 1; d < SIDE; d++) begin
            column[d] = lb_word[(d-1)*DW +: DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= o_q_pop;
            r_s2_valid <= r_s1_valid;
        end
        if (o_q_pop) begin
            r_s1          <= i_q_item;
            // same column written this edge: RAM returns the old word
            r_s1_fwd      <= r_s1_valid && (r_s1.col == i_q_item.col);
            r_s1_fwd_word <= lb_wdata;
        end
        if (ram_we) begin
            for (int d = 0; d < SIDE; d++) begin
                r_win[d][0] <= column[d];
                for (int j = 1; j < mf9_pkg::WIN_TAPS; j++) begin
                    r_win[d][j] <= r_win[d][j-1];
                end
            end
        end
        if (en) begin
            r_s2_emit    <= r_s1.emit;
            r_s2_last    <= r_s1.last;
            r_s2_out_row <= r_s1.out_row;
            r_s2_out_col <= r_s1.out_col;
        end
    end

    // select taps one pixel apart and zero everything outside the frame
    always_comb begin
        logic signed [RPOS_W-1:0] rpos;
        logic signed [CPOS_W-1:0] cpos;
        logic [SIDE-1:0]          row_ok;
        logic [SIDE-1:0]          col_ok;
        logic [DW-1:0]            tap [SIDE][SIDE];
        for (int r = 0; r < SIDE; r++) begin
            rpos = $signed({2'b00, r_s2_out_row}) + $signed(RPOS_W'(r - RAD));
            row_ok[r] = (rpos >= 0) && (rpos < $signed({2'b00, i_geom.rows}));
        end
        for (int c = 0; c < SIDE; c++) begin
            cpos = $signed({3'b000, r_s2_out_col}) + $signed(CPOS_W'(c - RAD));
            for (int d = 0; d < SIDE; d++) begin
                tap[d][c] = r_win[d][SIDE-1-c];
            end
            for (int k = 2; k <= mf9_pkg::MAX_COMP; k++) begin
                if (i_geom.comp == mf9_pkg::COMP_W'(k)) begin
                    cpos = $signed({3'b000, r_s2_out_col}) + $signed(CPOS_W'((c - RAD) * k));
                    for (int d = 0; d < SIDE; d++) begin
                        tap[d][c] = r_win[d][(SIDE-1-c)*k];
                    end
                end
            end
            col_ok[c] = (cpos >= 0) && (cpos < $signed({2'b00, i_geom.row_bytes}));
        end
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                vals[r*SIDE+c] = (row_ok[r] && col_ok[c]) ? tap[SIDE-1-r][c] : '0;
            end
        end
    end

    mf9_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s2_valid && r_s2_emit),
        .i_last   (r_s2_last),
        .i_vals   (vals),
        .o_valid  (med_valid),
        .o_last   (med_last),
        .o_median (med_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= med_valid;
        end
        if (en) begin
            r_out.median_byte   <= med_byte;
            r_out.last_of_frame <= med_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_lb_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && ram_we && (i_q_item.col == r_s1.col)) |=> r_s1_fwd)
        else $error("line buffer read-after-write not forwarded");

endmodule

// ===== rtl/core/median_filter_9x9_zero_pad.sv =====
// ----------------------------------------------------------------------------
// median_filter_9x9_zero_pad: 9x9 zero-padded median over interleaved bytes
// Lag: a byte's median leaves 4*row_bytes + 4*components transactions
//   later, passing through the queue, line store RAM and median stages.
// Throughput: one transaction per cycle unless the queue is full; the line
//   store reads and writes one column word every cycle while steps advance.
// Reset: synchronous, active low; clears counters, sets 640x480x3; the line
//   store is not cleared.
// ----------------------------------------------------------------------------
module median_filter_9x9_zero_pad (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  mf9_pkg::t_in_item              i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output mf9_pkg::t_out_item             o_data,
    input  logic                           i_cfg_we,
    input  logic [mf9_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mf9_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int WW = mf9_pkg::WIDTH_W;
    localparam int HW = mf9_pkg::HEIGHT_W;
    localparam int CW = mf9_pkg::COMP_W;
    localparam int LW = mf9_pkg::LEAD_W;

    logic [WW-1:0] r_cfg_width;
    logic [HW-1:0] r_cfg_height;
    logic [CW-1:0] r_cfg_comp;

    logic              restart;
    logic [WW-1:0]     eff_w;
    logic [CW-1:0]     eff_c;
    logic [WW+CW-1:0]  prod;
    mf9_pkg::t_geom    geom;

    logic           push, q_full, q_nempty, q_pop;
    mf9_pkg::t_step push_item, q_head;

    assign restart = i_cfg_we && (i_cfg_idx == mf9_pkg::CFG_FRAME_WIDTH
                               || i_cfg_idx == mf9_pkg::CFG_FRAME_HEIGHT
                               || i_cfg_idx == mf9_pkg::CFG_COMP_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WW'(mf9_pkg::RST_FRAME_WIDTH);
            r_cfg_height <= HW'(mf9_pkg::RST_FRAME_HEIGHT);
            r_cfg_comp   <= CW'(mf9_pkg::RST_COMP_COUNT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mf9_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_wdata[WW-1:0];
                mf9_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_wdata[HW-1:0];
                mf9_pkg::CFG_COMP_COUNT:   r_cfg_comp   <= i_cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize width and component count clamp to the limit
    always_comb begin
        eff_w = r_cfg_width;
        if (r_cfg_width == '0) begin
            eff_w = WW'(1);
        end else if (r_cfg_width > WW'(mf9_pkg::MAX_WIDTH)) begin
            eff_w = WW'(mf9_pkg::MAX_WIDTH);
        end
        eff_c = r_cfg_comp;
        if (r_cfg_comp == '0) begin
            eff_c = CW'(1);
        end else if (r_cfg_comp > CW'(mf9_pkg::MAX_COMP)) begin
            eff_c = CW'(mf9_pkg::MAX_COMP);
        end
        prod           = eff_w * eff_c;
        geom.row_bytes = prod[mf9_pkg::RB_W-1:0];
        geom.rows      = (r_cfg_height == '0) ? HW'(1) : r_cfg_height;
        geom.comp      = eff_c;
        geom.lag       = (LW'(geom.row_bytes) + LW'(eff_c)) * LW'(mf9_pkg::RADIUS);
    end

    mf9_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_restart (restart),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_full    (q_full),
        .o_push    (push),
        .o_item    (push_item)
    );

    mf9_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_nempty (q_nempty),
        .o_full   (q_full)
    );

    mf9_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_q_nempty (q_nempty),
        .i_q_item   (q_head),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

// ===== dv/mf9_checker.sv =====
// ----------------------------------------------------------------------------
// mf9_checker: scoreboard for the 9x9 zero-padded median filter
// Watches the configuration port and both stream channels. It keeps its own
// copy of the frame geometry and a byte store, works out each median, and
// compares every output transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mf9_checker
    import mf9_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 2 * RADIUS * LINE_BYTES + 2 * RADIUS * MAX_COMP + 1;

    logic [DATA_W-1:0]   pix_mem [STORE_DEPTH];
    logic [WIDTH_W-1:0]  reg_width;
    logic [HEIGHT_W-1:0] reg_height;
    logic [COMP_W-1:0]   reg_comp;
    int unsigned         wr_col, wr_row, rd_col, rd_row, lead;
    t_out_item           median_q [$];

    function automatic int unsigned eff_comp();
        int unsigned c;
        c = reg_comp;
        if (c == 0) c = 1;
        if (c > MAX_COMP) c = MAX_COMP;
        return c;
    endfunction

    function automatic int unsigned eff_width();
        int unsigned w;
        w = reg_width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (reg_height == 0) ? 1 : reg_height;
    endfunction

    // 41st smallest of the 81 same-component neighbours, zero outside
    function automatic logic [DATA_W-1:0] window_median(int unsigned row_bytes,
                                                        int unsigned rows,
                                                        int unsigned comp);
        int hist [256];
        int r, c, seen;
        for (int v = 0; v < 256; v++) hist[v] = 0;
        for (int dr = -RADIUS; dr <= RADIUS; dr++) begin
            r = int'(rd_row) + dr;
            for (int dc = -RADIUS; dc <= RADIUS; dc++) begin
                c = int'(rd_col) + dc * int'(comp);
                if (r < 0 || r >= int'(rows) || c < 0 || c >= int'(row_bytes)) begin
                    hist[0]++;
                end else begin
                    hist[pix_mem[(r * row_bytes + c) % STORE_DEPTH]]++;
                end
            end
        end
        seen = 0;
        for (int v = 0; v < 256; v++) begin
            seen += hist[v];
            if (seen >= MEDIAN_RANK) return v[DATA_W-1:0];
        end
        return '1;
    endfunction

    task automatic restart_frame();
        wr_col = 0;
        wr_row = 0;
        rd_col = 0;
        rd_row = 0;
        lead   = 0;
    endtask

    task automatic predict_step(t_in_item item);
        int unsigned comp, row_bytes, rows, lag;
        t_out_item   res;
        comp      = eff_comp();
        row_bytes = eff_width() * comp;
        rows      = eff_height();
        lag       = RADIUS * row_bytes + RADIUS * comp;
        if (wr_row < rows) begin
            // flush while image bytes are still due: drop
            if (item.flush) return;
            pix_mem[(wr_row * row_bytes + wr_col) % STORE_DEPTH] = item.pixel_byte;
            wr_col++;
            if (wr_col >= row_bytes) begin
                wr_col = 0;
                wr_row++;
            end
        end
        if (lead < lag) begin
            lead++;
            return;
        end
        res.median_byte = window_median(row_bytes, rows, comp);
        rd_col++;
        if (rd_col >= row_bytes) begin
            rd_col = 0;
            rd_row++;
        end
        res.last_of_frame = (rd_row >= rows);
        median_q.insert(median_q.size(), res);
        if (res.last_of_frame) restart_frame();
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            reg_width    = WIDTH_W'(RST_FRAME_WIDTH);
            reg_height   = HEIGHT_W'(RST_FRAME_HEIGHT);
            reg_comp     = COMP_W'(RST_COMP_COUNT);
            restart_frame();
            median_q.delete();
            o_fail_count = 0;
            o_results    = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_WIDTH: begin
                        reg_width = i_cfg_wdata[WIDTH_W-1:0];
                        restart_frame();
                    end
                    CFG_FRAME_HEIGHT: begin
                        reg_height = i_cfg_wdata[HEIGHT_W-1:0];
                        restart_frame();
                    end
                    CFG_COMP_COUNT: begin
                        reg_comp = i_cfg_wdata[COMP_W-1:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            // retire before predicting so a same-edge push cannot match
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (median_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected output median=%0d last=%0b", $realtime,
                                 i_out_data.median_byte, i_out_data.last_of_frame);
                end else begin
                    want = median_q.pop_front();
                    if (want !== i_out_data) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch median exp=%0d got=%0d last exp=%0b got=%0b",
                                     $realtime, want.median_byte, i_out_data.median_byte,
                                     want.last_of_frame, i_out_data.last_of_frame);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_step(i_in_data);
        end
        o_pending = median_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for median_filter_9x9_zero_pad
// Streams frames of many geometries with flush tails, random gaps on both
// channels and ignored noise items; a checker module scores every output.
// ----------------------------------------------------------------------------
module tb_top;
    import mf9_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid, in_ready;
    t_in_item              in_data;
    logic                  out_valid, out_ready;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count, pending, results;
    int                    items_sent, frames_sent, idle_cycles;
    bit                    quiet, sender_gaps, sink_gaps;
    int                    stall_left;
    int unsigned           geo_w, geo_h, geo_c;

    median_filter_9x9_zero_pad DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_data     (in_data),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_data     (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    mf9_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_results   (results)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready = 1'b0;
        end else if (!quiet && sink_gaps && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            out_ready  = 1'b0;
        end else begin
            out_ready = 1'b1;
        end
    end

    // watchdog: cycles with no transaction and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("median_filter_9x9_zero_pad test failed");
                $finish;
            end
        end
    end

    task automatic send_item(logic [DATA_W-1:0] pix, logic fl);
        int gap;
        if (!quiet && sender_gaps && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        in_valid        = 1'b1;
        in_data.pixel_byte = pix;
        in_data.flush      = fl;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        in_valid = 1'b0;
        items_sent++;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // write all three registers on an idle block; keep the effective geometry
    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned c);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(CFG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(CFG_COMP_COUNT, c[CFG_DATA_W-1:0]);
        geo_w = w[WIDTH_W-1:0];
        geo_h = h[HEIGHT_W-1:0];
        geo_c = c[COMP_W-1:0];
        if (geo_w == 0) geo_w = 1;
        if (geo_w > MAX_WIDTH) geo_w = MAX_WIDTH;
        if (geo_h == 0) geo_h = 1;
        if (geo_c == 0) geo_c = 1;
        if (geo_c > MAX_COMP) geo_c = MAX_COMP;
    endtask

    // mode: 0 random, 1 all 0xFF, 2 all zero
    task automatic send_frame(int mode);
        int unsigned nbytes, lag;
        logic [DATA_W-1:0] pix;
        nbytes = geo_w * geo_c * geo_h;
        lag    = RADIUS * geo_w * geo_c + RADIUS * geo_c;
        sender_gaps = $urandom_range(0, 3) != 0;
        sink_gaps   = $urandom_range(0, 3) != 0;
        for (int unsigned k = 0; k < nbytes; k++) begin
            // flush mid-frame is ignored by the block
            if ($urandom_range(0, 15) == 0)
                send_item(DATA_W'($urandom_range(0, 255)), 1'b1);
            pix = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : DATA_W'($urandom_range(0, 255));
            send_item(pix, 1'b0);
        end
        // drain tail: pixel bytes here are dropped and act as flush
        for (int unsigned k = 0; k < lag; k++)
            send_item(DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        frames_sent++;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_FRAME_WIDTH;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        sender_gaps = 1'b0;
        sink_gaps   = 1'b0;
        stall_left  = 0;
        items_sent  = 0;
        frames_sent = 0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: tiny frames, saturated and zero data, zero registers
        set_geometry(1, 1, 1);
        send_frame(1);
        set_geometry(0, 0, 0);
        send_frame(2);
        set_geometry(3, 2, 2);
        send_frame(1);

        // oversize component count, then a full window inside the frame
        set_geometry(2, 3, 7);
        send_frame(0);
        set_geometry(9, 9, 1);
        send_frame(0);

        // random small geometries, one or two frames per setting
        while (items_sent < 950) begin
            set_geometry($urandom_range(0, 5), $urandom_range(0, 6),
                         $urandom_range(0, 5));
            repeat ($urandom_range(1, 2)) send_frame(0);
        end
        // closing stretch without random gaps on either channel
        quiet = 1'b1;
        set_geometry(5, 5, 2);
        send_frame(0);

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        $display("Covered %0d frames, %0d input transactions, %0d medians checked.",
                 frames_sent, items_sent, results);
        $display("Geometries ran from 1x1x1 up to 9x9, with zero and oversize register values.");
        if (fail_count == 0) begin
            $display("median_filter_9x9_zero_pad test passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("median_filter_9x9_zero_pad test failed");
        end
        $finish;
    end

endmodule
